// File: sv/sdc_pkg.sv
// Shared types, constants and palette tables for the spectrum detector and colormap.
`default_nettype none

package sdc_pkg;

    localparam int MAX_BINS = 1024;
    localparam int SAMPLE_W = 16;
    localparam int BIN_AW   = $clog2(MAX_BINS);
    localparam int FRAME_W  = BIN_AW + 1;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 11;
    localparam int LEVEL_W  = 8;

    localparam logic [FRAME_W-1:0] FRAME_MAX = FRAME_W'(MAX_BINS);
    localparam logic [FRAME_W-1:0] FRAME_MIN = FRAME_W'(1);

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_DETECTOR_MODE  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_GAIN_SETTING   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ZERO_SETTING   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_PALETTE_SELECT = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_FRAME_BINS     = 3'd4;

    localparam logic [7:0] GAIN_RESET = 8'd50;
    localparam logic [7:0] ZERO_RESET = 8'd50;

    typedef enum logic [1:0] {
        DET_RAW      = 2'd0,
        DET_MAX_HOLD = 2'd1,
        DET_AVERAGE  = 2'd2
    } det_mode_t;

    typedef enum logic [1:0] {
        PAL_HEAT  = 2'd0,
        PAL_GREEN = 2'd1,
        PAL_GRAY  = 2'd2
    } pal_sel_t;

    typedef struct packed {
        det_mode_t          mode;
        logic [FRAME_W-1:0] frame_bins;
        logic               restart;
    } hist_cfg_t;

    // Average: floor((3v + 7h + 5) / 10), offset to a positive range first
    localparam int AVG_W = 20;
    localparam logic signed [AVG_W-1:0] AVG_ROUND  = 20'sd5;
    localparam logic signed [AVG_W-1:0] AVG_OFFSET = 20'sd327680;
    localparam logic [AVG_W-1:0]        AVG_RECIP  = 20'd838861;
    localparam int AVG_SHIFT = 23;

    // Level: floor(p * 255 / 40960000) = floor(((p * 51) >> 16) / 125)
    localparam logic signed [31:0] LEVEL_SAT   = 32'sd40960000;
    localparam logic [31:0]        LEVEL_MUL   = 32'd51;
    localparam logic [30:0]        LEVEL_RECIP = 31'd33555;
    localparam logic signed [8:0]  ZERO_BIAS   = 9'sd50;

    typedef logic [255:0][23:0] pal_tab_t;

    localparam int PAL_ENDS [3][5][3][2] = '{
        '{ '{'{0, 0},   '{0, 0},   '{1, 5}},
           '{'{0, 0},   '{0, 8},   '{5, 8}},
           '{'{0, 0},   '{8, 10},  '{8, 0}},
           '{'{0, 10},  '{10, 10}, '{0, 0}},
           '{'{10, 10}, '{10, 0},  '{0, 0}} },
        '{ '{'{0, 0},   '{5, 15},  '{0, 0}},
           '{'{0, 10},  '{15, 50}, '{0, 5}},
           '{'{10, 50}, '{50, 80}, '{5, 20}},
           '{'{50, 100},'{80, 100},'{20, 50}},
           '{'{0, 0},   '{0, 0},   '{0, 0}} },
        '{ '{'{0, 100}, '{0, 100}, '{0, 100}},
           '{'{0, 0},   '{0, 0},   '{0, 0}},
           '{'{0, 0},   '{0, 0},   '{0, 0}},
           '{'{0, 0},   '{0, 0},   '{0, 0}},
           '{'{0, 0},   '{0, 0},   '{0, 0}} }
    };

    // Elaboration-time palette build: red in [23:16], green in [15:8], blue in [7:0]
    function automatic pal_tab_t build_palette(input int sel);
        pal_tab_t tab;
        int mult;
        int segs;
        int i;
        int k;
        int j;
        int c;
        int a;
        int b;
        int x;
        int lv;
        mult = (sel == 0) ? 5 : ((sel == 1) ? 4 : 1);
        segs = mult;
        for (i = 0; i < 256; i++) begin
            k = (mult * i) / 255;
            if (k >= segs) begin
                k = segs - 1;
            end
            j = mult * i - 255 * k;
            for (c = 0; c < 3; c++) begin
                a = PAL_ENDS[sel][k][c][0];
                b = PAL_ENDS[sel][k][c][1];
                x = a * 255 + (b - a) * j;
                lv = (sel == 0) ? (x + 5) / 10 : (x + 50) / 100;
                tab[i][23 - 8 * c -: 8] = lv[7:0];
            end
        end
        return tab;
    endfunction

    localparam pal_tab_t PAL_HEAT_TAB  = build_palette(0);
    localparam pal_tab_t PAL_GREEN_TAB = build_palette(1);
    localparam pal_tab_t PAL_GRAY_TAB  = build_palette(2);

endpackage

`default_nettype wire

// File: sv/sdc_scale.sv
// Three-stage gain and offset scaler that turns a Q2.14 value into a clamped 8-bit level.
`default_nettype none

module sdc_scale import sdc_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       advance,
    input  wire logic [7:0]                 gain,
    input  wire logic [7:0]                 zero,
    input  wire logic signed [SAMPLE_W-1:0] value,
    output logic [LEVEL_W-1:0]              level
);

    logic signed [8:0]  zoff;
    logic signed [23:0] x_c;
    logic signed [31:0] p_c;
    logic signed [31:0] p_reg;

    logic [31:0] m_prod;
    logic        nonpos_c;
    logic        sat_c;
    logic [14:0] m_reg;
    logic        nonpos_reg;
    logic        sat_reg;

    logic [30:0]        q_prod;
    logic [LEVEL_W-1:0] level_next;
    logic [LEVEL_W-1:0] level_reg;

    // x = 50*v + 2^14*(zero - 50), then times gain
    always_comb begin
        zoff = $signed({1'b0, zero}) - ZERO_BIAS;
        x_c  = (24'(value) <<< 5) + (24'(value) <<< 4) + (24'(value) <<< 1)
             + (24'(zoff) <<< 14);
        p_c  = 32'(x_c) * 32'($signed({1'b0, gain}));
    end

    always_comb begin
        nonpos_c = (p_reg <= 32'sd0);
        sat_c    = (p_reg >= LEVEL_SAT);
        m_prod   = 32'(p_reg[25:0]) * LEVEL_MUL;
    end

    // Divide by 125 through the reciprocal; exact below 2^15
    always_comb begin
        q_prod = 31'(m_reg) * LEVEL_RECIP;
        if (nonpos_reg) begin
            level_next = '0;
        end else if (sat_reg) begin
            level_next = '1;
        end else begin
            level_next = q_prod[29:22];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p_reg      <= p_c;
            m_reg      <= m_prod[30:16];
            nonpos_reg <= nonpos_c;
            sat_reg    <= sat_c;
            level_reg  <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

// File: sv/sdc_history.sv
// Per-bin history memory with read-modify-write detector, bypass and frame position.
`default_nettype none

module sdc_history import sdc_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire hist_cfg_t                  cfg,
    input  wire logic                       accept,
    input  wire logic                       advance,
    input  wire logic                       s1_valid,
    input  wire logic signed [SAMPLE_W-1:0] bin_value,
    output logic signed [SAMPLE_W-1:0]      raw_s1,
    output logic signed [SAMPLE_W-1:0]      det_s2,
    output logic                            last_s2
);

    logic [SAMPLE_W-1:0] hist_mem [MAX_BINS];

    logic [BIN_AW-1:0]  pos_reg;
    logic [BIN_AW-1:0]  pos_next;
    logic               hv_reg;
    logic               hv_next;
    logic [FRAME_W-1:0] pos_inc;
    logic               last_c;

    logic signed [SAMPLE_W-1:0] v1_reg;
    logic [BIN_AW-1:0]          addr1_reg;
    logic                       last1_reg;
    logic [SAMPLE_W-1:0]        rd_reg;
    logic                       byp_hit_reg;
    logic signed [SAMPLE_W-1:0] byp_data_reg;

    logic signed [SAMPLE_W-1:0] hist_c;
    logic signed [AVG_W-1:0]    avg_sum;
    logic [AVG_W-1:0]           avg_off;
    logic [2*AVG_W-1:0]         avg_prod;
    logic [SAMPLE_W-1:0]        avg_q;
    logic signed [SAMPLE_W-1:0] det_c;
    logic                       wr_en;

    logic signed [SAMPLE_W-1:0] det2_reg;
    logic                       last2_reg;

    always_comb begin
        pos_inc = {1'b0, pos_reg} + FRAME_W'(1);
        last_c  = (pos_inc >= cfg.frame_bins);
        if (cfg.restart) begin
            pos_next = '0;
        end else if (accept) begin
            pos_next = last_c ? '0 : pos_inc[BIN_AW-1:0];
        end else begin
            pos_next = pos_reg;
        end
    end

    // Take the entry still in flight when the previous bin wrote the same address
    always_comb begin
        hist_c   = byp_hit_reg ? byp_data_reg : $signed(rd_reg);
        avg_sum  = (20'(v1_reg) <<< 1) + 20'(v1_reg) + (20'(hist_c) <<< 3) - 20'(hist_c)
                 + AVG_ROUND;
        avg_off  = avg_sum + AVG_OFFSET;
        avg_prod = 40'(avg_off) * 40'(AVG_RECIP);
        avg_q    = avg_prod[AVG_SHIFT +: SAMPLE_W];
        case (cfg.mode)
            DET_MAX_HOLD: det_c = (hv_reg && hist_c > v1_reg) ? hist_c : v1_reg;
            DET_AVERAGE:  det_c = hv_reg ? $signed({~avg_q[SAMPLE_W-1], avg_q[SAMPLE_W-2:0]})
                                         : v1_reg;
            default:      det_c = v1_reg;
        endcase
        wr_en = s1_valid && advance
             && (cfg.mode == DET_MAX_HOLD || cfg.mode == DET_AVERAGE);
        if (cfg.restart) begin
            hv_next = 1'b0;
        end else if (wr_en && last1_reg) begin
            hv_next = 1'b1;
        end else begin
            hv_next = hv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            hv_reg  <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            hv_reg  <= hv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[addr1_reg] <= det_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= hist_mem[pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            v1_reg       <= bin_value;
            addr1_reg    <= pos_reg;
            last1_reg    <= last_c;
            byp_hit_reg  <= wr_en && (addr1_reg == pos_reg);
            byp_data_reg <= det_c;
        end
        if (advance) begin
            det2_reg  <= det_c;
            last2_reg <= last1_reg;
        end
    end

    assign raw_s1  = v1_reg;
    assign det_s2  = det2_reg;
    assign last_s2 = last2_reg;

`ifndef SYNTH
    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg.restart |-> ({1'b0, pos_reg} < cfg.frame_bins))
        else $error("bin position beyond frame length");

    a_raw_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg.mode == DET_RAW) |-> !wr_en)
        else $error("history written in raw mode");

    a_frame_end_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && last1_reg && !cfg.restart) |=> hv_reg)
        else $error("history not marked valid after a full frame");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.restart |=> (!hv_reg && pos_reg == '0))
        else $error("restart did not clear history state");
`endif

endmodule

`default_nettype wire

// File: sv/spectrum_detector_colormap_top.sv
// A bin goes via stage 1, det2, det3, det4 and the output register to m_.
// Throughput: one bin per cycle unless m_ready stalls; history is read at accept
// and written back from stage 1, with a one-entry bypass for back-to-back bins.
// Reset (aresetn, synchronous): configuration to its defaults, pipeline empty,
// bin position and history-valid cleared; the history memory is not cleared.
`default_nettype none

module spectrum_detector_colormap_top import sdc_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_AW-1:0]          cfg_index,
    input  wire logic [CFG_DW-1:0]          cfg_data,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [SAMPLE_W-1:0] s_bin_value,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [SAMPLE_W-1:0]      m_detected_value,
    output logic [LEVEL_W-1:0]              m_trace_level,
    output logic [LEVEL_W-1:0]              m_color_index,
    output logic [LEVEL_W-1:0]              m_red_level,
    output logic [LEVEL_W-1:0]              m_green_level,
    output logic [LEVEL_W-1:0]              m_blue_level,
    output logic                            m_frame_last
);

    det_mode_t          mode_reg;
    det_mode_t          mode_next;
    logic [7:0]         gain_reg;
    logic [7:0]         gain_next;
    logic [7:0]         zero_reg;
    logic [7:0]         zero_next;
    pal_sel_t           pal_reg;
    pal_sel_t           pal_next;
    logic [FRAME_W-1:0] frame_reg;
    logic [FRAME_W-1:0] frame_next;
    logic               restart;
    logic               cfg_we;
    hist_cfg_t          hcfg;

    logic advance;
    logic accept;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic out_valid_reg;

    logic signed [SAMPLE_W-1:0] raw_s1;
    logic signed [SAMPLE_W-1:0] det_s2;
    logic                       last_s2;
    logic signed [SAMPLE_W-1:0] det3_reg;
    logic signed [SAMPLE_W-1:0] det4_reg;
    logic signed [SAMPLE_W-1:0] det_out_reg;
    logic                       last3_reg;
    logic                       last4_reg;
    logic                       last_out_reg;
    logic [LEVEL_W-1:0]         cidx_s4;
    logic [LEVEL_W-1:0]         cidx_out_reg;
    logic [LEVEL_W-1:0]         trace_out;
    logic [23:0]                rgb_c;
    logic [23:0]                rgb_out_reg;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Drop writes of unused mode and palette codes; saturate the frame length
    always_comb begin
        mode_next  = mode_reg;
        gain_next  = gain_reg;
        zero_next  = zero_reg;
        pal_next   = pal_reg;
        frame_next = frame_reg;
        restart    = 1'b0;
        if (cfg_we) begin
            case (cfg_index)
                CFG_DETECTOR_MODE: begin
                    if (cfg_data[1:0] inside {DET_RAW, DET_MAX_HOLD, DET_AVERAGE}) begin
                        mode_next = det_mode_t'(cfg_data[1:0]);
                        restart   = 1'b1;
                    end
                end
                CFG_GAIN_SETTING: gain_next = cfg_data[7:0];
                CFG_ZERO_SETTING: zero_next = cfg_data[7:0];
                CFG_PALETTE_SELECT: begin
                    if (cfg_data[1:0] inside {PAL_HEAT, PAL_GREEN, PAL_GRAY}) begin
                        pal_next = pal_sel_t'(cfg_data[1:0]);
                    end
                end
                CFG_FRAME_BINS: begin
                    if (cfg_data[FRAME_W-1:0] == '0) begin
                        frame_next = FRAME_MIN;
                    end else if (cfg_data[FRAME_W-1:0] > FRAME_MAX) begin
                        frame_next = FRAME_MAX;
                    end else begin
                        frame_next = cfg_data[FRAME_W-1:0];
                    end
                    restart = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= DET_RAW;
            gain_reg  <= GAIN_RESET;
            zero_reg  <= ZERO_RESET;
            pal_reg   <= PAL_HEAT;
            frame_reg <= FRAME_MAX;
        end else begin
            mode_reg  <= mode_next;
            gain_reg  <= gain_next;
            zero_reg  <= zero_next;
            pal_reg   <= pal_next;
            frame_reg <= frame_next;
        end
    end

    // Restart acts in the same cycle as the write, against the new settings
    always_comb begin
        hcfg.mode       = mode_next;
        hcfg.frame_bins = frame_next;
        hcfg.restart    = restart;
    end

    // Whole pipeline advances together whenever the output register can move
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg        <= accept;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    sdc_history u_history (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (hcfg),
        .accept    (accept),
        .advance   (advance),
        .s1_valid  (v1_reg),
        .bin_value (s_bin_value),
        .raw_s1    (raw_s1),
        .det_s2    (det_s2),
        .last_s2   (last_s2)
    );

    sdc_scale u_scale_raw (
        .aclk    (aclk),
        .advance (advance),
        .gain    (gain_reg),
        .zero    (zero_reg),
        .value   (raw_s1),
        .level   (cidx_s4)
    );

    sdc_scale u_scale_det (
        .aclk    (aclk),
        .advance (advance),
        .gain    (gain_reg),
        .zero    (zero_reg),
        .value   (det_s2),
        .level   (trace_out)
    );

    always_comb begin
        case (pal_reg)
            PAL_GREEN: rgb_c = PAL_GREEN_TAB[cidx_s4];
            PAL_GRAY:  rgb_c = PAL_GRAY_TAB[cidx_s4];
            default:   rgb_c = PAL_HEAT_TAB[cidx_s4];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            det3_reg     <= det_s2;
            det4_reg     <= det3_reg;
            det_out_reg  <= det4_reg;
            last3_reg    <= last_s2;
            last4_reg    <= last3_reg;
            last_out_reg <= last4_reg;
            cidx_out_reg <= cidx_s4;
            rgb_out_reg  <= rgb_c;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_detected_value = det_out_reg;
    assign m_trace_level    = trace_out;
    assign m_color_index    = cidx_out_reg;
    assign m_red_level      = rgb_out_reg[23:16];
    assign m_green_level    = rgb_out_reg[15:8];
    assign m_blue_level     = rgb_out_reg[7:0];
    assign m_frame_last     = last_out_reg;

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the spectrum detector with waterfall color map.
module tb;
    import sdc_pkg::*;

    localparam int    RANDOM_BINS = 88;
    localparam int    LONG_EXTRA  = 16;
    localparam int    IDLE_LIMIT  = 2000;
    localparam longint FRAC_ONE   = longint'(1) << (SAMPLE_W - 2);
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] PAL_UNUSED  = 2'd3;

    // Segment end points per palette, segment and component, in units of 1/scale
    localparam int COLOR_KNOTS [3][5][3][2] = '{
        '{ '{'{0, 0},   '{0, 0},   '{1, 5}},
           '{'{0, 0},   '{0, 8},   '{5, 8}},
           '{'{0, 0},   '{8, 10},  '{8, 0}},
           '{'{0, 10},  '{10, 10}, '{0, 0}},
           '{'{10, 10}, '{10, 0},  '{0, 0}} },
        '{ '{'{0, 0},   '{5, 15},  '{0, 0}},
           '{'{0, 10},  '{15, 50}, '{0, 5}},
           '{'{10, 50}, '{50, 80}, '{5, 20}},
           '{'{50, 100},'{80, 100},'{20, 50}},
           '{'{0, 0},   '{0, 0},   '{0, 0}} },
        '{ '{'{0, 100}, '{0, 100}, '{0, 100}},
           '{'{0, 0},   '{0, 0},   '{0, 0}},
           '{'{0, 0},   '{0, 0},   '{0, 0}},
           '{'{0, 0},   '{0, 0},   '{0, 0}},
           '{'{0, 0},   '{0, 0},   '{0, 0}} }
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] detected;
        logic [LEVEL_W-1:0]         trace;
        logic [LEVEL_W-1:0]         cindex;
        logic [LEVEL_W-1:0]         red;
        logic [LEVEL_W-1:0]         green;
        logic [LEVEL_W-1:0]         blue;
        logic                       frame_end;
    } bin_result_t;

    logic                       aclk;
    logic                       aresetn     = 1'b0;
    logic                       cfg_valid   = 1'b0;
    logic                       cfg_ready;
    logic [CFG_AW-1:0]          cfg_index   = '0;
    logic [CFG_DW-1:0]          cfg_data    = '0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_bin_value = '0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic signed [SAMPLE_W-1:0] m_detected_value;
    logic [LEVEL_W-1:0]         m_trace_level;
    logic [LEVEL_W-1:0]         m_color_index;
    logic [LEVEL_W-1:0]         m_red_level;
    logic [LEVEL_W-1:0]         m_green_level;
    logic [LEVEL_W-1:0]         m_blue_level;
    logic                       m_frame_last;

    spectrum_detector_colormap_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_bin_value      (s_bin_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_detected_value (m_detected_value),
        .m_trace_level    (m_trace_level),
        .m_color_index    (m_color_index),
        .m_red_level      (m_red_level),
        .m_green_level    (m_green_level),
        .m_blue_level     (m_blue_level),
        .m_frame_last     (m_frame_last)
    );

    // Detector and display settings as the block should hold them
    det_mode_t          det_mode  = DET_RAW;
    logic [7:0]         gain      = GAIN_RESET;
    logic [7:0]         zero_off  = ZERO_RESET;
    pal_sel_t           palette   = PAL_HEAT;
    int                 frame_len = MAX_BINS;
    logic signed [SAMPLE_W-1:0] hist_mem [MAX_BINS];
    bit                 hist_loaded = 1'b0;
    int                 bin_pos     = 0;

    logic signed [SAMPLE_W-1:0] pending_bins [$];
    bin_result_t                expected_bins [$];
    bin_result_t                seen_bin;
    bin_result_t                want_bin;

    int send_gap     = 0;
    int stall_left   = 0;
    int idle_cycles  = 0;
    int results_seen = 0;
    int bad_results  = 0;
    bit quiet_phase  = 1'b0;
    bit steady       = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [LEVEL_W-1:0] level_of(input longint v);
        longint num;
        longint q;
        num = (50 * v + FRAC_ONE * (longint'(zero_off) - 50)) * longint'(gain) * 255;
        if (num <= 0) return '0;
        q = num / (FRAC_ONE * 2500);
        return (q > 255) ? 8'd255 : LEVEL_W'(q);
    endfunction

    function automatic longint floor_tenth(input longint s);
        return (s >= 0) ? s / 10 : -((-s + 9) / 10);
    endfunction

    function automatic logic [23:0] palette_rgb(input logic [LEVEL_W-1:0] idx);
        int p;
        int segs;
        int scl;
        int k;
        int j;
        int a;
        int b;
        int n;
        int lv;
        logic [23:0] rgb;
        p    = int'(palette);
        segs = (palette == PAL_HEAT) ? 5 : ((palette == PAL_GREEN) ? 4 : 1);
        scl  = (palette == PAL_HEAT) ? 10 : 100;
        k    = (segs * int'(idx)) / 255;
        if (k >= segs) k = segs - 1;
        j = segs * int'(idx) - 255 * k;
        for (int c = 0; c < 3; c++) begin
            a  = COLOR_KNOTS[p][k][c][0];
            b  = COLOR_KNOTS[p][k][c][1];
            // interpolate and round half up
            n  = 2 * 255 * (a * 255 + (b - a) * j) + scl * 255;
            lv = n / (2 * scl * 255);
            if (lv > 255) lv = 255;
            else if (lv < 0) lv = 0;
            rgb[23 - 8 * c -: 8] = lv[7:0];
        end
        return rgb;
    endfunction

    function automatic bin_result_t predict_bin(input logic signed [SAMPLE_W-1:0] raw);
        bin_result_t r;
        longint v;
        longint h;
        longint d;
        int pos;
        bit last;
        v    = raw;
        d    = v;
        pos  = bin_pos;
        last = (pos + 1 >= frame_len);
        if (det_mode == DET_MAX_HOLD || det_mode == DET_AVERAGE) begin
            if (hist_loaded) begin
                h = hist_mem[pos];
                if (det_mode == DET_MAX_HOLD) d = (v > h) ? v : h;
                else d = floor_tenth(3 * v + 7 * h + 5);
            end
            hist_mem[pos] = SAMPLE_W'(d);
            if (last) hist_loaded = 1'b1;
        end
        bin_pos     = last ? 0 : pos + 1;
        r.detected  = SAMPLE_W'(d);
        r.trace     = level_of(d);
        r.cindex    = level_of(v);
        {r.red, r.green, r.blue} = palette_rgb(r.cindex);
        r.frame_end = last;
        return r;
    endfunction

    function automatic void apply_reg(input logic [CFG_AW-1:0] idx,
                                      input logic [CFG_DW-1:0] data);
        case (idx)
            CFG_DETECTOR_MODE: begin
                if (data[1:0] != MODE_UNUSED) begin
                    det_mode    = det_mode_t'(data[1:0]);
                    hist_loaded = 1'b0;
                    bin_pos     = 0;
                end
            end
            CFG_GAIN_SETTING: gain = data[7:0];
            CFG_ZERO_SETTING: zero_off = data[7:0];
            CFG_PALETTE_SELECT: begin
                if (data[1:0] != PAL_UNUSED) palette = pal_sel_t'(data[1:0]);
            end
            CFG_FRAME_BINS: begin
                if (data == '0) frame_len = int'(FRAME_MIN);
                else if (data > CFG_DW'(FRAME_MAX)) frame_len = int'(FRAME_MAX);
                else frame_len = int'(data);
                hist_loaded = 1'b0;
                bin_pos     = 0;
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_bin();
        case ($urandom_range(0, 9))
            0: return SAMPLE_W'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            2: return SAMPLE_W'($urandom_range(16384, 32767));
            default: return SAMPLE_W'($urandom_range(0, 16384));
        endcase
    endfunction

    function automatic logic [7:0] pick_setting();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom);
            default: return 8'($urandom_range(30, 70));
        endcase
    endfunction

    function automatic logic [CFG_DW-1:0] pick_frame();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_DW'($urandom_range(1025, 2047));
            2: return CFG_DW'(MAX_BINS);
            default: return CFG_DW'($urandom_range(1, 48));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic wait_idle();
        while (pending_bins.size() != 0 || s_valid || expected_bins.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Bin request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_bins.push_back(predict_bin(s_bin_value));
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_bins.size() != 0) begin
                    s_valid     <= 1'b1;
                    s_bin_value <= pending_bins.pop_front();
                    if (!steady && !quiet_phase && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 8);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                seen_bin = '{m_detected_value, m_trace_level, m_color_index,
                             m_red_level, m_green_level, m_blue_level, m_frame_last};
                results_seen++;
                if (expected_bins.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("result %0d arrived with nothing expected: det=%0d",
                                 results_seen, seen_bin.detected);
                end else begin
                    want_bin = expected_bins.pop_front();
                    if (seen_bin.detected !== want_bin.detected
                        || seen_bin.trace !== want_bin.trace
                        || seen_bin.cindex !== want_bin.cindex
                        || seen_bin.red !== want_bin.red
                        || seen_bin.green !== want_bin.green
                        || seen_bin.blue !== want_bin.blue
                        || seen_bin.frame_end !== want_bin.frame_end) begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display({"result %0d mismatch: exp det=%0d trace=%0d idx=%0d",
                                      " rgb=%02h%02h%02h last=%0b | got det=%0d trace=%0d",
                                      " idx=%0d rgb=%02h%02h%02h last=%0b"},
                                     results_seen, want_bin.detected, want_bin.trace,
                                     want_bin.cindex, want_bin.red, want_bin.green,
                                     want_bin.blue, want_bin.frame_end,
                                     seen_bin.detected, seen_bin.trace, seen_bin.cindex,
                                     seen_bin.red, seen_bin.green, seen_bin.blue,
                                     seen_bin.frame_end);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_ready <= 1'b0;
            end else if (!steady && !quiet_phase && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Abort when no channel moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int n;
        int sent;
        int round;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Raw mode at reset settings: sign, full scale and overrange corners
        pending_bins = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff,
                         16'sh4000, 16'sh2000, 16'sh0ccd, 16'sh3fff, 16'sh5555};
        wait_idle();

        // Zero frame length saturates to one bin; max-hold from the second bin on
        write_reg(CFG_FRAME_BINS, '0);
        write_reg(CFG_DETECTOR_MODE, CFG_DW'(DET_MAX_HOLD));
        pending_bins = '{16'sd1000, 16'sd500, 16'sd20000, 16'sh8000, 16'sh7fff};
        wait_idle();

        write_reg(CFG_DETECTOR_MODE, CFG_DW'(DET_AVERAGE));
        write_reg(CFG_GAIN_SETTING, CFG_DW'(8'd255));
        write_reg(CFG_ZERO_SETTING, CFG_DW'(8'd0));
        pending_bins = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sd100};
        wait_idle();

        // Unused mode and palette codes: no change, history stays loaded
        write_reg(CFG_DETECTOR_MODE, CFG_DW'(MODE_UNUSED));
        write_reg(CFG_PALETTE_SELECT, CFG_DW'(PAL_UNUSED));
        pending_bins = '{16'sh7fff, 16'sh0000, 16'sh2aaa};
        wait_idle();

        // Full-length frame, oversize write saturates to the store depth
        write_reg(CFG_FRAME_BINS, '1);
        write_reg(CFG_DETECTOR_MODE, CFG_DW'(DET_MAX_HOLD));
        write_reg(CFG_PALETTE_SELECT, CFG_DW'(PAL_GRAY));
        write_reg(CFG_GAIN_SETTING, CFG_DW'(GAIN_RESET));
        write_reg(CFG_ZERO_SETTING, CFG_DW'(ZERO_RESET));
        for (int i = 0; i < MAX_BINS + LONG_EXTRA; i++) pending_bins.push_back(pick_bin());
        wait_idle();

        sent  = 0;
        round = 0;
        while (sent < RANDOM_BINS) begin
            quiet_phase = ($urandom_range(0, 4) == 0);
            steady      = (RANDOM_BINS - sent <= 60);
            if (round == 0) begin
                write_reg(CFG_DETECTOR_MODE, CFG_DW'(DET_AVERAGE));
                write_reg(CFG_GAIN_SETTING, CFG_DW'(8'd0));
                write_reg(CFG_ZERO_SETTING, CFG_DW'(8'd255));
                write_reg(CFG_PALETTE_SELECT, CFG_DW'(PAL_GREEN));
                write_reg(CFG_FRAME_BINS, CFG_DW'(16));
            end else begin
                if ($urandom_range(0, 1))
                    write_reg(CFG_DETECTOR_MODE, CFG_DW'($urandom_range(0, 3)));
                if ($urandom_range(0, 1)) write_reg(CFG_GAIN_SETTING, CFG_DW'(pick_setting()));
                if ($urandom_range(0, 1)) write_reg(CFG_ZERO_SETTING, CFG_DW'(pick_setting()));
                if ($urandom_range(0, 1))
                    write_reg(CFG_PALETTE_SELECT, CFG_DW'($urandom_range(0, 3)));
                if ($urandom_range(0, 2) == 0) write_reg(CFG_FRAME_BINS, pick_frame());
                // undecoded indexes must be ignored
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_AW'($urandom_range(int'(CFG_FRAME_BINS) + 1,
                                                     (1 << CFG_AW) - 1)),
                              CFG_DW'($urandom));
            end
            n = $urandom_range(20, 60);
            for (int i = 0; i < n; i++) begin
                pending_bins.push_back(pick_bin());
                // hold the sender until everything in flight has drained
                if ((round == 1 || $urandom_range(0, 99) == 0) && i == n / 2) wait_idle();
            end
            sent += n;
            round++;
            wait_idle();
        end

        if (bad_results == 0 && expected_bins.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: spectrum_detector_colormap_top.f
sv/sdc_pkg.sv
sv/sdc_scale.sv
sv/sdc_history.sv
sv/spectrum_detector_colormap_top.sv
dv/tb.sv
